@@ design/nrbc_pkg.sv @@
package nrbc_pkg;

  localparam int DEGREE    = 3;
  localparam int FRAC_BITS = 28;

  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;

  localparam longint ONE_RAW  = longint'(1) <<< FRAC_BITS;
  localparam longint DINI_RAW = longint'(DEGREE) <<< FRAC_BITS;

  localparam logic signed [31:0] ONE_FX = 32'(ONE_RAW > SAT_HI ? SAT_HI : ONE_RAW);
  localparam logic signed [31:0] D_INIT = 32'(DINI_RAW > SAT_HI ? SAT_HI : DINI_RAW);

  localparam logic [63:0] STEP_THRESH =
    ((64'd1 << (2 * FRAC_BITS)) + 64'd99999999) / 64'd100000000;

  localparam logic [1:0] DEG_TOP = 2'(DEGREE - 1);

  localparam logic [2:0] REG_ROOT_A    = 3'd0;
  localparam logic [2:0] REG_ROOT_B    = 3'd1;
  localparam logic [2:0] REG_ROOT_C    = 3'd2;
  localparam logic [2:0] REG_COEF_ZERO = 3'd3;
  localparam logic [2:0] REG_COEF_ONE  = 3'd4;
  localparam logic [2:0] REG_COEF_TWO  = 3'd5;
  localparam logic [2:0] REG_ITER_LIM  = 3'd6;

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    if (v > 40'sd2147483647) return 32'sh7fffffff;
    if (v < -40'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [39:0] fsh(input logic signed [65:0] v);
    logic signed [65:0] s;
    s = v >>> FRAC_BITS;
    return s[39:0];
  endfunction

  function automatic logic signed [31:0] zero_div(input logic signed [31:0] p);
    if (p > 32'sd0) return 32'sh80000000;
    if (p < 32'sd0) return 32'sh7fffffff;
    return 32'sd0;
  endfunction

endpackage

@@ design/newton_root_basin_classifier.sv @@
// Each item runs N evaluated Newton steps (N = 1 .. max(1, iteration_limit)); a step whose
// derivative norm is zero skips the divider.
// A new item is taken only once the previous result is loaded, which waits while m_tready
// holds a result; s_tready is high only while the sequencer is idle.
// One 33x33 multiplier and one bit-serial divider do the work.
// Reset (rst, synchronous): sequencer idle, no result held, previous root 0,
// roots and coefficients 0, iteration limit 20.
module newton_root_basin_classifier import nrbc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // start_re [31:0], start_im [63:32]
  input  logic        s_tuser,   // column_start
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // root_index [1:0], edge_res [2], iterations_used [10:3],
                                 // converged [11], zero [15:12]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_PHORN = 9'b000000010,
    S_DHORN = 9'b000000100,
    S_NORM  = 9'b000001000,
    S_NUM   = 9'b000010000,
    S_DIV   = 9'b000100000,
    S_SQ    = 9'b001000000,
    S_DIST  = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state;

  logic [63:0] root_a, root_b, root_c, coef_zero, coef_one, coef_two;
  logic [7:0]  iteration_limit;

  logic signed [31:0] z_re, z_im, w_re, w_im, p_re, p_im, t_re, dl_re, dl_im;
  logic signed [39:0] acc;
  logic [63:0]        acc64;
  logic [35:0]        n;
  logic signed [36:0] nr, ni;
  logic [2:0]         ph;
  logic [1:0]         k;
  logic [7:0]         steps;
  logic               col, conv;
  logic [63:0]        best;
  logic [1:0]         best_idx, prev_root;
  logic [35:0]        rem;
  logic [31:0]        dvd, quo;
  logic [4:0]         dcnt;
  logic               dsel, ovf;

  logic signed [32:0] ma, mb;
  logic signed [65:0] prod;

  logic signed [39:0] fs, kx, cs_re, cs_im;
  logic [63:0]        coef_k, root_k;
  logic signed [31:0] add_re, add_im, cm_re, cm_im, im_t;
  logic [64:0]        sum64;
  logic [35:0]        n_calc;
  logic signed [32:0] dr_k, di_k;
  logic signed [36:0] num;
  logic [36:0]        mag;
  logic [63:0]        dividend;
  logic               ovf_c, ge, num_pos;
  logic [36:0]        r2;
  logic [35:0]        r2_sub;
  logic [32:0]        qv;
  logic signed [31:0] q_res;
  logic [63:0]        dsq;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    unique case (k)
      2'd0:    begin coef_k = coef_zero; root_k = root_a; end
      2'd1:    begin coef_k = coef_one;  root_k = root_b; end
      default: begin coef_k = coef_two;  root_k = root_c; end
    endcase
    kx    = {38'd0, k};
    cs_re = 40'(signed'(coef_k[63:32])) * kx;
    cs_im = 40'(signed'(coef_k[31:0])) * kx;
    if (state == S_DHORN) begin
      add_re = sat32(cs_re);
      add_im = sat32(cs_im);
    end else begin
      add_re = signed'(coef_k[63:32]);
      add_im = signed'(coef_k[31:0]);
    end
    fs     = fsh(prod);
    im_t   = sat32(acc + fs);
    cm_re  = sat32(40'(t_re) + 40'(add_re));
    cm_im  = sat32(40'(im_t) + 40'(add_im));
    sum64  = 65'(acc64) + 65'(prod[63:0]);
    n_calc = sum64[63:FRAC_BITS];
    dsq    = sum64[64] ? '1 : sum64[63:0];
    dr_k   = 33'(z_re) - 33'(signed'(root_k[63:32]));
    di_k   = 33'(z_im) - 33'(signed'(root_k[31:0]));

    num      = dsel ? ni : nr;
    mag      = num[36] ? 37'(-num) : 37'(num);
    dividend = 64'(mag) << FRAC_BITS;
    ovf_c    = {4'd0, dividend} >= {n, 32'd0};
    r2       = {rem, dvd[31]};
    ge       = r2 >= {1'b0, n};
    r2_sub   = 36'(r2 - {1'b0, n});
    num_pos  = !num[36] && (num != 37'sd0);
    qv       = ovf ? 33'h1_0000_0000 : {1'b0, quo};
    if (num_pos) q_res = (qv > 33'h0_8000_0000) ? 32'sh80000000 : -signed'(qv[31:0]);
    else         q_res = (qv > 33'h0_7fff_ffff) ? 32'sh7fffffff : signed'(qv[31:0]);
  end

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state)
      S_PHORN, S_DHORN: begin
        unique case (ph)
          3'd0:    begin ma = 33'(w_re); mb = 33'(z_re); end
          3'd1:    begin ma = 33'(w_im); mb = 33'(z_im); end
          3'd2:    begin ma = 33'(w_re); mb = 33'(z_im); end
          3'd3:    begin ma = 33'(w_im); mb = 33'(z_re); end
          default: ;
        endcase
      end
      S_NORM: begin
        unique case (ph)
          3'd0:    begin ma = 33'(w_re); mb = 33'(w_re); end
          3'd1:    begin ma = 33'(w_im); mb = 33'(w_im); end
          default: ;
        endcase
      end
      S_NUM: begin
        unique case (ph)
          3'd0:    begin ma = 33'(p_re); mb = 33'(w_re); end
          3'd1:    begin ma = 33'(p_im); mb = 33'(w_im); end
          3'd2:    begin ma = 33'(p_im); mb = 33'(w_re); end
          3'd3:    begin ma = 33'(p_re); mb = 33'(w_im); end
          default: ;
        endcase
      end
      S_SQ: begin
        unique case (ph)
          3'd0:    begin ma = 33'(dl_re); mb = 33'(dl_re); end
          3'd1:    begin ma = 33'(dl_im); mb = 33'(dl_im); end
          default: ;
        endcase
      end
      S_DIST: begin
        unique case (ph)
          3'd0:    begin ma = dr_k; mb = dr_k; end
          3'd1:    begin ma = di_k; mb = di_k; end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      m_tvalid        <= 1'b0;
      prev_root       <= '0;
      root_a          <= '0;
      root_b          <= '0;
      root_c          <= '0;
      coef_zero       <= '0;
      coef_one        <= '0;
      coef_two        <= '0;
      iteration_limit <= 8'd20;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_ROOT_A:    root_a <= cfg_data;
          REG_ROOT_B:    root_b <= cfg_data;
          REG_ROOT_C:    root_c <= cfg_data;
          REG_COEF_ZERO: coef_zero <= cfg_data;
          REG_COEF_ONE:  coef_one <= cfg_data;
          REG_COEF_TWO:  coef_two <= cfg_data;
          REG_ITER_LIM:  iteration_limit <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (m_tready && state != S_OUT) m_tvalid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            z_re  <= signed'(s_tdata[31:0]);
            z_im  <= signed'(s_tdata[63:32]);
            col   <= s_tuser;
            steps <= '0;
            w_re  <= ONE_FX;
            w_im  <= '0;
            k     <= DEG_TOP;
            ph    <= '0;
            state <= S_PHORN;
          end
        end
        S_PHORN, S_DHORN: begin
          if (ph == 3'd1 || ph == 3'd3) acc <= fs;
          if (ph == 3'd2) t_re <= sat32(acc - fs);
          if (ph == 3'd4) begin
            ph <= '0;
            if (state == S_PHORN && k == 2'd0) begin
              p_re  <= cm_re;
              p_im  <= cm_im;
              w_re  <= D_INIT;
              w_im  <= '0;
              k     <= DEG_TOP;
              state <= S_DHORN;
            end else begin
              w_re <= cm_re;
              w_im <= cm_im;
              if (state == S_DHORN && k == 2'd1) begin
                state <= S_NORM;
              end else begin
                k <= k - 2'd1;
              end
            end
          end else begin
            ph <= ph + 3'd1;
          end
        end
        S_NORM: begin
          if (ph == 3'd1) acc64 <= prod[63:0];
          if (ph == 3'd2) begin
            ph <= '0;
            n  <= n_calc;
            if (n_calc == '0) begin
              dl_re <= zero_div(p_re);
              dl_im <= zero_div(p_im);
              state <= S_SQ;
            end else begin
              state <= S_NUM;
            end
          end else begin
            ph <= ph + 3'd1;
          end
        end
        S_NUM: begin
          if (ph == 3'd1 || ph == 3'd3) acc <= fs;
          if (ph == 3'd2) nr <= 37'(acc + fs);
          if (ph == 3'd4) begin
            ni    <= 37'(acc - fs);
            ph    <= '0;
            dsel  <= 1'b0;
            state <= S_DIV;
          end else begin
            ph <= ph + 3'd1;
          end
        end
        S_DIV: begin
          unique case (ph)
            3'd0: begin
              ovf  <= ovf_c;
              rem  <= 36'(dividend[63:32]);
              dvd  <= dividend[31:0];
              quo  <= '0;
              dcnt <= '0;
              ph   <= 3'd1;
            end
            3'd1: begin
              rem  <= ge ? r2_sub : r2[35:0];
              quo  <= {quo[30:0], ge};
              dvd  <= {dvd[30:0], 1'b0};
              dcnt <= dcnt + 5'd1;
              if (dcnt == 5'd31) ph <= 3'd2;
            end
            default: begin
              ph <= '0;
              if (!dsel) begin
                dl_re <= q_res;
                dsel  <= 1'b1;
              end else begin
                dl_im <= q_res;
                state <= S_SQ;
              end
            end
          endcase
        end
        S_SQ: begin
          if (ph == 3'd1) acc64 <= prod[63:0];
          if (ph == 3'd2) begin
            ph <= '0;
            if (sum64 < 65'(STEP_THRESH)) begin
              conv  <= 1'b1;
              k     <= '0;
              state <= S_DIST;
            end else begin
              z_re  <= sat32(40'(z_re) + 40'(dl_re));
              z_im  <= sat32(40'(z_im) + 40'(dl_im));
              steps <= steps + 8'd1;
              conv  <= 1'b0;
              if ({1'b0, steps} + 9'd1 < {1'b0, iteration_limit}) begin
                w_re  <= ONE_FX;
                w_im  <= '0;
                k     <= DEG_TOP;
                state <= S_PHORN;
              end else begin
                k     <= '0;
                state <= S_DIST;
              end
            end
          end else begin
            ph <= ph + 3'd1;
          end
        end
        S_DIST: begin
          if (ph == 3'd1) acc64 <= prod[63:0];
          if (ph == 3'd2) begin
            ph <= '0;
            if (k == 2'd0 || dsq < best) begin
              best     <= dsq;
              best_idx <= k;
            end
            if (k == DEG_TOP) state <= S_OUT;
            else k <= k + 2'd1;
          end else begin
            ph <= ph + 3'd1;
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid  <= 1'b1;
            m_tdata   <= {4'd0, conv, steps,
                          best_idx != (col ? 2'd0 : prev_root), best_idx};
            prev_root <= best_idx;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_state_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("sequencer state not one-hot");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("ready high right after an item was taken");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT && (!m_tvalid || m_tready) |=> m_tvalid && state == S_IDLE)
    else $error("result not presented");

  a_root_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[1:0] != 2'd3)
    else $error("root index out of range");

endmodule

@@ sim/nrbc_checker.sv @@
`timescale 1ns / 100ps

module nrbc_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [63:0] s_tdata,
  input  logic        s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output int          errors,
  output int          pending
);

  typedef struct {
    longint re;
    longint im;
  } cplx_t;

  typedef struct {
    logic [1:0] root_index;
    logic       edge_res;
    logic [7:0] iterations_used;
    logic       converged;
  } basin_t;

  logic [63:0] roots_reg [3];
  logic [63:0] coefs_reg [3];
  logic [7:0]  iter_limit;
  logic [1:0]  last_root;
  basin_t      basin_q [$];

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint floor_fx(longint v);
    return v >>> nrbc_pkg::FRAC_BITS;
  endfunction

  function automatic cplx_t unpack_fx(logic [63:0] r);
    cplx_t c;
    c.re = longint'($signed(r[63:32]));
    c.im = longint'($signed(r[31:0]));
    return c;
  endfunction

  function automatic cplx_t c_add(cplx_t a, cplx_t b);
    cplx_t r;
    r.re = clamp32(a.re + b.re);
    r.im = clamp32(a.im + b.im);
    return r;
  endfunction

  function automatic cplx_t c_mul(cplx_t a, cplx_t b);
    cplx_t r;
    r.re = clamp32(floor_fx(a.re * b.re) - floor_fx(a.im * b.im));
    r.im = clamp32(floor_fx(a.re * b.im) + floor_fx(a.im * b.re));
    return r;
  endfunction

  function automatic cplx_t c_scale(cplx_t a, longint k);
    cplx_t r;
    r.re = clamp32(a.re * k);
    r.im = clamp32(a.im * k);
    return r;
  endfunction

  function automatic longint step_comp(longint num, logic [63:0] n);
    logic [63:0] mag;
    logic [63:0] q;
    mag = (num < 0) ? 64'(-num) : 64'(num);
    q = (mag << nrbc_pkg::FRAC_BITS) / n;
    if (num > 0) begin
      if (q > 64'd2147483648) q = 64'd2147483648;
      return -longint'(q);
    end
    if (q > 64'd2147483647) q = 64'd2147483647;
    return longint'(q);
  endfunction

  function automatic longint flat_comp(longint p);
    if (p > 0) return -64'sd2147483648;
    if (p < 0) return 64'sd2147483647;
    return 0;
  endfunction

  function automatic logic [63:0] dist_sq(cplx_t a, cplx_t b);
    longint dr, di;
    logic [63:0] ur, ui, s1, s2;
    dr = a.re - b.re;
    di = a.im - b.im;
    ur = (dr < 0) ? 64'(-dr) : 64'(dr);
    ui = (di < 0) ? 64'(-di) : 64'(di);
    s1 = ur * ur;
    s2 = ui * ui;
    if (s1 > ~64'd0 - s2) return ~64'd0;
    return s1 + s2;
  endfunction

  function automatic basin_t classify(logic [63:0] pt, logic col_start);
    cplx_t z, one, p, d, dl;
    logic [63:0] n, sq, best, dst;
    longint nr, ni;
    int steps, lim, k;
    logic conv;
    logic [1:0] idx;
    basin_t res;
    z.re = longint'($signed(pt[31:0]));
    z.im = longint'($signed(pt[63:32]));
    one.re = clamp32(longint'(1) <<< nrbc_pkg::FRAC_BITS);
    one.im = 0;
    lim = iter_limit;
    steps = 0;
    conv = 1'b0;
    do begin
      p = one;
      for (k = nrbc_pkg::DEGREE - 1; k >= 0; k--)
        p = c_add(c_mul(p, z), unpack_fx(coefs_reg[k]));
      d = c_scale(one, nrbc_pkg::DEGREE);
      for (k = nrbc_pkg::DEGREE - 1; k >= 1; k--)
        d = c_add(c_mul(d, z), c_scale(unpack_fx(coefs_reg[k]), k));
      n = (64'(d.re * d.re) + 64'(d.im * d.im)) >> nrbc_pkg::FRAC_BITS;
      if (n == 0) begin
        dl.re = flat_comp(p.re);
        dl.im = flat_comp(p.im);
      end else begin
        nr = floor_fx(p.re * d.re) + floor_fx(p.im * d.im);
        ni = floor_fx(p.im * d.re) - floor_fx(p.re * d.im);
        dl.re = step_comp(nr, n);
        dl.im = step_comp(ni, n);
      end
      sq = 64'(dl.re * dl.re) + 64'(dl.im * dl.im);
      if (sq < nrbc_pkg::STEP_THRESH) begin
        conv = 1'b1;
        break;
      end
      z = c_add(z, dl);
      steps++;
    end while (steps < lim);
    idx = 2'd0;
    best = dist_sq(z, unpack_fx(roots_reg[0]));
    for (k = 1; k < nrbc_pkg::DEGREE; k++) begin
      dst = dist_sq(z, unpack_fx(roots_reg[k]));
      if (dst < best) begin
        best = dst;
        idx = 2'(k);
      end
    end
    res.root_index = idx;
    res.edge_res = idx != (col_start ? 2'd0 : last_root);
    res.iterations_used = 8'(steps);
    res.converged = conv;
    last_root = idx;
    return res;
  endfunction

  assign pending = basin_q.size();

  always @(posedge clk) begin
    basin_t got, want;
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        roots_reg[i] = '0;
        coefs_reg[i] = '0;
      end
      iter_limit = 8'd20;
      last_root = 2'd0;
      errors = 0;
      basin_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          nrbc_pkg::REG_ROOT_A:    roots_reg[0] = cfg_data;
          nrbc_pkg::REG_ROOT_B:    roots_reg[1] = cfg_data;
          nrbc_pkg::REG_ROOT_C:    roots_reg[2] = cfg_data;
          nrbc_pkg::REG_COEF_ZERO: coefs_reg[0] = cfg_data;
          nrbc_pkg::REG_COEF_ONE:  coefs_reg[1] = cfg_data;
          nrbc_pkg::REG_COEF_TWO:  coefs_reg[2] = cfg_data;
          nrbc_pkg::REG_ITER_LIM:  iter_limit = cfg_data[7:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got.root_index = m_tdata[1:0];
        got.edge_res = m_tdata[2];
        got.iterations_used = m_tdata[10:3];
        got.converged = m_tdata[11];
        if (basin_q.size() == 0) begin
          $error("result item with nothing expected: %h", m_tdata);
          errors++;
        end else begin
          want = basin_q.pop_front();
          if (got.root_index !== want.root_index) begin
            $error("root_index: expected %0d, got %0d", want.root_index, got.root_index);
            errors++;
          end
          if (got.edge_res !== want.edge_res) begin
            $error("edge_res: expected %0d, got %0d", want.edge_res, got.edge_res);
            errors++;
          end
          if (got.iterations_used !== want.iterations_used) begin
            $error("iterations_used: expected %0d, got %0d",
                   want.iterations_used, got.iterations_used);
            errors++;
          end
          if (got.converged !== want.converged) begin
            $error("converged: expected %0d, got %0d", want.converged, got.converged);
            errors++;
          end
        end
      end
      if (s_tvalid && s_tready)
        basin_q.push_back(classify(s_tdata, s_tuser));
    end
  end

endmodule

@@ sim/tb_newton_root_basin_classifier.sv @@
`timescale 1ns / 100ps

module tb_newton_root_basin_classifier;

  localparam logic [31:0] FX_ONE = 32'h1000_0000;
  localparam logic [31:0] FX_HALF = 32'h0800_0000;
  localparam logic [31:0] FX_SQ3H = 32'h0DDB_3D74;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;
  int          errors;
  int          pending;
  bit          no_gaps;
  int          results_seen = 0;

  newton_root_basin_classifier u_top (.*);

  nrbc_checker u_chk (.*);

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  initial begin
    #40000000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [31:0] rand_fx();
    if ($urandom_range(3) == 0) return $urandom();
    return 32'($signed($urandom_range(32'h4000_0000)) - 32'sh2000_0000);
  endfunction

  task automatic pixel(logic [31:0] re, logic [31:0] im, logic col);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(6);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {im, re};
    s_tuser <= col;
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(negedge clk);
    wait (pending == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic unity_roots(logic [7:0] lim);
    write_reg(nrbc_pkg::REG_ROOT_A, {FX_ONE, 32'd0});
    write_reg(nrbc_pkg::REG_ROOT_B, {-FX_HALF, FX_SQ3H});
    write_reg(nrbc_pkg::REG_ROOT_C, {-FX_HALF, -FX_SQ3H});
    write_reg(nrbc_pkg::REG_COEF_ZERO, {-FX_ONE, 32'd0});
    write_reg(nrbc_pkg::REG_COEF_ONE, 64'd0);
    write_reg(nrbc_pkg::REG_COEF_TWO, 64'd0);
    write_reg(nrbc_pkg::REG_ITER_LIM, {56'd0, lim});
  endtask

  task automatic random_pixels(int cnt);
    for (int i = 0; i < cnt; i++)
      pixel(rand_fx(), rand_fx(), $urandom_range(4) == 0);
  endtask

  always @(posedge clk) begin
    if (m_tvalid && m_tready) results_seen <= results_seen + 1;
  end

  initial begin
    int gap;
    m_tready <= 1'b0;
    @(negedge rst);
    @(posedge clk);
    forever begin
      gap = no_gaps ? 0 : $urandom_range(6);
      if (results_seen == 30) begin
        m_tready <= 1'b0;
        repeat (10000) @(posedge clk);
      end else if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(negedge clk);
      while (!m_tvalid) @(negedge clk);
      @(posedge clk);
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    no_gaps = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    pixel(32'd0, 32'd0, 1'b1);
    pixel(FX_ONE, FX_ONE, 1'b0);
    pixel(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    pixel(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    drain();

    unity_roots(8'd20);
    pixel(32'd0, 32'd0, 1'b1);
    pixel(FX_ONE, 32'd0, 1'b0);
    pixel(-FX_HALF, FX_SQ3H, 1'b0);
    pixel(-FX_HALF, -FX_SQ3H, 1'b0);
    pixel(-FX_ONE, 32'd0, 1'b0);
    pixel(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    pixel(32'h8000_0000, 32'h8000_0000, 1'b0);
    pixel(32'hFFFF_FFFF, 32'h0000_0001, 1'b0);
    pixel(FX_HALF, FX_HALF, 1'b1);
    drain();
    random_pixels(60);
    no_gaps = 1'b1;
    random_pixels(60);
    no_gaps = 1'b0;
    drain();
    random_pixels(120);
    drain();

    write_reg(nrbc_pkg::REG_ROOT_A, {32'h7FFF_FFFF, 32'h7FFF_FFFF});
    write_reg(nrbc_pkg::REG_ROOT_B, {32'h8000_0000, 32'h8000_0000});
    write_reg(nrbc_pkg::REG_ROOT_C, {32'h7FFF_FFFF, 32'h7FFF_FFFF});
    pixel(32'h8000_0000, 32'h8000_0000, 1'b0);
    pixel(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    pixel(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    drain();

    for (int c = 0; c < 8; c++) begin
      write_reg(nrbc_pkg::REG_ROOT_A, {rand_fx(), rand_fx()});
      write_reg(nrbc_pkg::REG_ROOT_B, {rand_fx(), rand_fx()});
      write_reg(nrbc_pkg::REG_ROOT_C, {rand_fx(), rand_fx()});
      write_reg(nrbc_pkg::REG_COEF_ZERO, {rand_fx(), rand_fx()});
      write_reg(nrbc_pkg::REG_COEF_ONE, {rand_fx(), rand_fx()});
      write_reg(nrbc_pkg::REG_COEF_TWO, {rand_fx(), rand_fx()});
      write_reg(nrbc_pkg::REG_ITER_LIM, {$urandom(), 24'($urandom()), 8'($urandom_range(1, 10))});
      no_gaps = (c == 3);
      random_pixels(45);
      drain();
    end
    no_gaps = 1'b0;

    unity_roots(8'd255);
    pixel(32'd0, 32'd0, 1'b1);
    random_pixels(4);
    drain();

    unity_roots(8'd0);
    pixel(32'd0, 32'd0, 1'b1);
    random_pixels(15);
    drain();
    write_reg(nrbc_pkg::REG_ITER_LIM, 64'd1);
    random_pixels(20);
    drain();

    repeat (200) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
